>>> hdl/nsd_pkg.sv
// shared types, sizes and codes for the ncc stereo disparity unit
// no dependencies; imported by every module of the block
`default_nettype none
package nsd_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_RANGE  = 64;
  localparam int MAX_WINDOW = 16;

  localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int NPIX_W    = ADDR_W + 1;
  localparam int X_W       = $clog2(MAX_WIDTH);
  localparam int Y_W       = $clog2(MAX_HEIGHT);
  localparam int UV_W      = $clog2(MAX_WINDOW);

  localparam int DIM_W     = 9;
  localparam int RANGE_W   = 7;
  localparam int WIN_W     = 5;
  localparam int PIX_W     = 8;
  localparam int DISP_W    = 7;
  localparam int CFG_IDX_W = 2;

  localparam int ACC_W     = 2 * PIX_W + 2 * UV_W;
  localparam int PROD_W    = 2 * ACC_W;
  localparam int SCORE_W   = 17;
  localparam int Q_W       = 33;
  localparam int DIV_CNT_W = $clog2(Q_W);
  localparam int SQ_BIT_W  = $clog2(SCORE_W);

  localparam logic [DISP_W-1:0] DISP_NONE = '1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DISP_RANGE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd3;

  typedef struct packed {
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [RANGE_W-1:0] range;
    logic [WIN_W-1:0]   win;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_READ,
    ST_PIX,
    ST_SHIFT,
    ST_WALK,
    ST_DRAIN,
    ST_MULT,
    ST_DIV,
    ST_SQRT,
    ST_CMP,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic cfg_restart;
    logic load_wr;
    logic load_restart;
    logic rd_issue;
    logic comp_start;
    logic pix_start;
    logic shift_start;
    logic walk_step;
    logic mult;
    logic div_step;
    logic sqrt_step;
    logic cmp;
    logic next_shift;
    logic write_res;
    logic next_pixel;
  } cmd_t;

  typedef struct packed {
    logic load_last;
    logic load_last0;
    logic read_last;
    logic walk_last;
    logic zero;
    logic div_last;
    logic sqrt_last;
    logic r_last;
    logic pix_last;
  } sts_t;

endpackage
`default_nettype wire

>>> hdl/nsd_ctrl.sv
// sequencer for load, per-pixel scoring and readback
// depends on nsd_pkg
`default_nettype none
module nsd_ctrl
  import nsd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_acc_i,
  input  logic in_op_i,
  input  logic cfg_we_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    busy_o  = !(state_q == ST_LOAD || state_q == ST_READ);
    priority if (cfg_we_i) begin
      cmd_o.cfg_restart = 1'b1;
      state_d = ST_LOAD;
    end else begin
      unique case (state_q)
        ST_LOAD: begin
          if (in_acc_i && in_op_i == OP_LOAD) begin
            cmd_o.load_wr = 1'b1;
            if (sts_i.load_last) begin
              cmd_o.comp_start = 1'b1;
              state_d = ST_PIX;
            end
          end
        end
        ST_READ: begin
          if (in_acc_i) begin
            if (in_op_i == OP_LOAD) begin
              cmd_o.load_restart = 1'b1;
              if (sts_i.load_last0) begin
                cmd_o.comp_start = 1'b1;
                state_d = ST_PIX;
              end else begin
                state_d = ST_LOAD;
              end
            end else begin
              cmd_o.rd_issue = 1'b1;
              if (sts_i.read_last) state_d = ST_LOAD;
            end
          end
        end
        ST_PIX: begin
          cmd_o.pix_start = 1'b1;
          state_d = ST_SHIFT;
        end
        ST_SHIFT: begin
          cmd_o.shift_start = 1'b1;
          state_d = ST_WALK;
        end
        ST_WALK: begin
          cmd_o.walk_step = 1'b1;
          if (sts_i.walk_last) state_d = ST_DRAIN;
        end
        ST_DRAIN: begin
          state_d = ST_MULT;
        end
        ST_MULT: begin
          cmd_o.mult = 1'b1;
          state_d = ST_DIV;
        end
        ST_DIV: begin
          // zero numerator or denominator skips the search
          if (sts_i.zero) begin
            state_d = ST_CMP;
          end else begin
            cmd_o.div_step = 1'b1;
            if (sts_i.div_last) state_d = ST_SQRT;
          end
        end
        ST_SQRT: begin
          cmd_o.sqrt_step = 1'b1;
          if (sts_i.sqrt_last) state_d = ST_CMP;
        end
        ST_CMP: begin
          cmd_o.cmp = 1'b1;
          if (sts_i.r_last) begin
            state_d = ST_WRITE;
          end else begin
            cmd_o.next_shift = 1'b1;
            state_d = ST_SHIFT;
          end
        end
        ST_WRITE: begin
          cmd_o.write_res = 1'b1;
          if (sts_i.pix_last) begin
            state_d = ST_READ;
          end else begin
            cmd_o.next_pixel = 1'b1;
            state_d = ST_PIX;
          end
        end
        default: begin
          state_d = ST_LOAD;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hdl/nsd_datapath.sv
// image stores, window accumulators, divider, square root and result store
// depends on nsd_pkg; driven by nsd_ctrl commands
`default_nettype none
module nsd_datapath
  import nsd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  cmd_t              cmd_i,
  input  logic [PIX_W-1:0]  left_pixel_i,
  input  logic [PIX_W-1:0]  right_pixel_i,
  output sts_t              sts_o,
  output logic [DISP_W-1:0] rd_data_o,
  output logic              rd_last_o
);

  logic [PIX_W-1:0]  left_mem  [MEM_DEPTH];
  logic [PIX_W-1:0]  right_mem [MEM_DEPTH];
  logic [DISP_W-1:0] shift_mem [MEM_DEPTH];

  logic [NPIX_W-1:0] npix;
  logic [ADDR_W-1:0] rptr_q;
  logic [ADDR_W-1:0] wr_addr;

  logic [X_W-1:0]    x_q;
  logic [Y_W-1:0]    y_q;
  logic [ADDR_W-1:0] pix_q;
  logic [RANGE_W-1:0] r_q;
  logic [UV_W-1:0]   u_q, v_q;
  logic [ADDR_W-1:0] row_addr_q;
  logic [ADDR_W-1:0] rd_addr, l_addr;
  logic              row_ok, col_ok, l_ok;
  logic              acc_v_q, l_ok_q;
  logic [PIX_W-1:0]  r_pix_q, l_pix_q;
  logic [2*PIX_W-1:0] rr, ll, rl;
  logic [ACC_W-1:0]  d1_q, d2_q, n_q;

  logic [PROD_W-1:0] nsq, p_q;
  logic              nsq0_q, zero_q;
  logic [PROD_W:0]   rem_q, rem_sh;
  logic              ge;
  logic [Q_W-1:0]    quo_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic              bit_in;
  logic [SCORE_W-1:0] sq_res_q, trial, cand, best_q;
  logic [SQ_BIT_W-1:0] sq_bit_q;
  logic [2*SCORE_W-1:0] tsq;
  logic [DISP_W-1:0] best_shift_q, shift_wr;
  logic [DISP_W-1:0] rd_data_q;
  logic              rd_last_q;

  assign npix = NPIX_W'(cfg_i.width) * NPIX_W'(cfg_i.height);

  assign sts_o.load_last  = (NPIX_W'(rptr_q) + 1'b1) == npix;
  assign sts_o.load_last0 = npix == NPIX_W'(1);
  assign sts_o.read_last  = (NPIX_W'(rptr_q) + 1'b1) == npix;
  assign sts_o.walk_last  = (WIN_W'(u_q) == cfg_i.win - 1'b1) &&
                            (WIN_W'(v_q) == cfg_i.win - 1'b1);
  assign sts_o.zero       = zero_q;
  assign sts_o.div_last   = div_cnt_q == '0;
  assign sts_o.sqrt_last  = sq_bit_q == '0;
  assign sts_o.r_last     = r_q == cfg_i.range;
  assign sts_o.pix_last   = (NPIX_W'(pix_q) + 1'b1) == npix;

  assign wr_addr = cmd_i.load_restart ? '0 : rptr_q;

  // window tap addressing and edge masks
  assign rd_addr = row_addr_q + ADDR_W'(u_q);
  assign l_addr  = rd_addr + ADDR_W'(r_q);
  assign row_ok  = (DIM_W'(y_q) + DIM_W'(v_q)) < cfg_i.height;
  assign col_ok  = (DIM_W'(x_q) + DIM_W'(u_q)) < cfg_i.width;
  assign l_ok    = ((DIM_W+1)'(x_q) + (DIM_W+1)'(u_q) + (DIM_W+1)'(r_q)) <
                   (DIM_W+1)'(cfg_i.width);

  assign rr = r_pix_q * r_pix_q;
  assign ll = l_pix_q * l_pix_q;
  assign rl = r_pix_q * l_pix_q;

  assign nsq    = n_q * n_q;
  assign bit_in = (div_cnt_q == DIV_CNT_W'(Q_W - 1)) ? nsq0_q : 1'b0;
  assign rem_sh = {rem_q[PROD_W-1:0], bit_in};
  assign ge     = rem_sh >= {1'b0, p_q};

  assign trial = sq_res_q | (SCORE_W'(1) << sq_bit_q);
  assign tsq   = trial * trial;

  assign cand     = zero_q ? '0 : sq_res_q;
  assign shift_wr = (best_shift_q == cfg_i.range) ? DISP_NONE : best_shift_q;

  assign rd_data_o = rd_data_q;
  assign rd_last_o = rd_last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr || cmd_i.load_restart) begin
      left_mem[wr_addr]  <= left_pixel_i;
      right_mem[wr_addr] <= right_pixel_i;
    end
    if (cmd_i.walk_step) begin
      r_pix_q <= right_mem[rd_addr];
      l_pix_q <= left_mem[l_addr];
    end
    if (cmd_i.write_res) begin
      shift_mem[pix_q] <= shift_wr;
    end
    if (cmd_i.rd_issue) begin
      rd_data_q <= shift_mem[rptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rptr_q    <= '0;
      acc_v_q   <= 1'b0;
      l_ok_q    <= 1'b0;
      rd_last_q <= 1'b0;
    end else begin
      acc_v_q <= cmd_i.walk_step && row_ok && col_ok;
      l_ok_q  <= cmd_i.walk_step && row_ok && l_ok;
      if (cmd_i.cfg_restart) begin
        rptr_q <= '0;
      end else if (cmd_i.load_wr) begin
        rptr_q <= sts_o.load_last ? '0 : rptr_q + 1'b1;
      end else if (cmd_i.load_restart) begin
        rptr_q <= sts_o.load_last0 ? '0 : ADDR_W'(1);
      end else if (cmd_i.rd_issue) begin
        rptr_q    <= sts_o.read_last ? '0 : rptr_q + 1'b1;
        rd_last_q <= sts_o.read_last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    // pixel and shift counters
    if (cmd_i.comp_start) begin
      x_q   <= '0;
      y_q   <= '0;
      pix_q <= '0;
    end else if (cmd_i.next_pixel) begin
      pix_q <= pix_q + 1'b1;
      if (DIM_W'(x_q) == cfg_i.width - 1'b1) begin
        x_q <= '0;
        y_q <= y_q + 1'b1;
      end else begin
        x_q <= x_q + 1'b1;
      end
    end

    if (cmd_i.pix_start) begin
      r_q          <= '0;
      best_q       <= '0;
      best_shift_q <= DISP_NONE;
    end else begin
      if (cmd_i.cmp && cand > best_q) begin
        best_q       <= cand;
        best_shift_q <= r_q;
      end
      if (cmd_i.next_shift) r_q <= r_q + 1'b1;
    end

    // window walk
    if (cmd_i.shift_start) begin
      u_q        <= '0;
      v_q        <= '0;
      row_addr_q <= pix_q;
    end else if (cmd_i.walk_step) begin
      if (WIN_W'(u_q) == cfg_i.win - 1'b1) begin
        u_q        <= '0;
        v_q        <= v_q + 1'b1;
        row_addr_q <= row_addr_q + ADDR_W'(cfg_i.width);
      end else begin
        u_q <= u_q + 1'b1;
      end
    end

    // box sums, right-only energy taken on the first shift
    if (cmd_i.pix_start) begin
      d1_q <= '0;
    end else if (acc_v_q && r_q == '0) begin
      d1_q <= d1_q + ACC_W'(rr);
    end
    if (cmd_i.shift_start) begin
      n_q  <= '0;
      d2_q <= '0;
    end else if (l_ok_q) begin
      n_q  <= n_q + ACC_W'(rl);
      d2_q <= d2_q + ACC_W'(ll);
    end

    // quotient of 2^32 n^2 by d1 d2, one bit a cycle
    if (cmd_i.mult) begin
      p_q       <= d1_q * d2_q;
      rem_q     <= (PROD_W+1)'(nsq >> 1);
      nsq0_q    <= nsq[0];
      zero_q    <= (n_q == '0) || (d1_q == '0) || (d2_q == '0);
      quo_q     <= '0;
      div_cnt_q <= DIV_CNT_W'(Q_W - 1);
    end else if (cmd_i.div_step) begin
      rem_q     <= ge ? rem_sh - {1'b0, p_q} : rem_sh;
      quo_q     <= {quo_q[Q_W-2:0], ge};
      div_cnt_q <= div_cnt_q - 1'b1;
    end

    // integer square root of the quotient, one bit a cycle
    if (cmd_i.mult) begin
      sq_res_q <= '0;
      sq_bit_q <= SQ_BIT_W'(SCORE_W - 1);
    end else if (cmd_i.sqrt_step) begin
      if (tsq <= (2*SCORE_W)'(quo_q)) sq_res_q <= trial;
      sq_bit_q <= sq_bit_q - 1'b1;
    end
  end

endmodule
`default_nettype wire

>>> hdl/ncc_stereo_disparity_unit.sv
// top level of the ncc stereo disparity unit: config registers, handshakes
// depends on nsd_pkg, nsd_ctrl and nsd_datapath
`default_nettype none
// A frame is loaded as raster pixel pairs (op 0, one transaction a cycle).
// Accepting the last pair starts scoring and the input stalls until every
// pixel is done; for each shift of each pixel the window is walked over the
// one read port of each image store, then the score is formed by a
// bit-serial divider and square root (a shift with zero correlation or
// energy skips both). Results are read back with op 1, one per transaction
// in raster order; a read result passes through the result store's read
// register into the output register, and the next request is taken once
// that result has entered the output register, even while the output is
// stalled. op 1 while loading is dropped, op 0 while reading starts a new
// frame. A config write restarts the frame; values are clamped to their
// legal ranges. No clearing pass is needed after reset.
module ncc_stereo_disparity_unit
  import nsd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 in_op_i,
  input  logic [PIX_W-1:0]     in_left_pixel_i,
  input  logic [PIX_W-1:0]     in_right_pixel_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [DISP_W-1:0] out_disparity_o,
  output logic                 out_last_pixel_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i
);

  cfg_t cfg_q, cfg_d;
  cmd_t cmd;
  sts_t sts;
  logic busy;
  logic in_acc;
  logic cfg_we;
  logic rd_pend_q, rd_pend_d;
  logic out_valid_q, out_valid_d;
  logic [DISP_W-1:0] out_disp_q;
  logic out_last_q;
  logic out_move;
  logic [DISP_W-1:0] rd_data;
  logic rd_last;

  // config port always ready
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // transactions held off while scoring or while a read is in flight
  assign in_stall_o = busy || rd_pend_q;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      unique case (cfg_index_i)
        REG_IMAGE_WIDTH: begin
          if (cfg_data_i == '0) cfg_d.width = DIM_W'(1);
          else if (cfg_data_i > DIM_W'(MAX_WIDTH)) cfg_d.width = DIM_W'(MAX_WIDTH);
          else cfg_d.width = cfg_data_i;
        end
        REG_IMAGE_HEIGHT: begin
          if (cfg_data_i == '0) cfg_d.height = DIM_W'(1);
          else if (cfg_data_i > DIM_W'(MAX_HEIGHT)) cfg_d.height = DIM_W'(MAX_HEIGHT);
          else cfg_d.height = cfg_data_i;
        end
        REG_DISP_RANGE: begin
          if (cfg_data_i[RANGE_W-1:0] == '0) cfg_d.range = RANGE_W'(1);
          else if (cfg_data_i[RANGE_W-1:0] > RANGE_W'(MAX_RANGE))
            cfg_d.range = RANGE_W'(MAX_RANGE);
          else cfg_d.range = cfg_data_i[RANGE_W-1:0];
        end
        REG_WINDOW_SIZE: begin
          if (cfg_data_i[WIN_W-1:0] == '0) cfg_d.win = WIN_W'(1);
          else if (cfg_data_i[WIN_W-1:0] > WIN_W'(MAX_WINDOW))
            cfg_d.win = WIN_W'(MAX_WINDOW);
          else cfg_d.win = cfg_data_i[WIN_W-1:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  // pending read moves into the output register when it is free
  assign out_move  = rd_pend_q && (!out_valid_q || !out_stall_i);
  assign rd_pend_d = (rd_pend_q && !out_move) || cmd.rd_issue;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_move) out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= DIM_W'(256);
      cfg_q.height <= DIM_W'(256);
      cfg_q.range  <= RANGE_W'(16);
      cfg_q.win    <= WIN_W'(5);
      rd_pend_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_move) begin
      out_disp_q <= rd_data;
      out_last_q <= rd_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_disparity_o  = out_disp_q;
  assign out_last_pixel_o = out_last_q;

  nsd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_acc_i (in_acc),
    .in_op_i  (in_op_i),
    .cfg_we_i (cfg_we),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  nsd_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cmd_i         (cmd),
    .left_pixel_i  (in_left_pixel_i),
    .right_pixel_i (in_right_pixel_i),
    .sts_o         (sts),
    .rd_data_o     (rd_data),
    .rd_last_o     (rd_last)
  );

`ifndef SYNTH
  // a read in flight must hold off new transactions
  a_pend_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> in_stall_o)
    else $error("transaction accepted while a read is in flight");

  // a pending read reaches the output once it is free
  a_pend_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_move |=> (out_valid_o && !rd_pend_q))
    else $error("pending read did not reach the output");

  // every result comes from a read request
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(rd_pend_q))
    else $error("result without a read request");
`endif

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// self-checking testbench for ncc_stereo_disparity_unit: loads small stereo frames,
// reads the disparities back and checks them against an in-bench predictor
// depends on nsd_pkg and the rtl of the unit
module tb;
  import nsd_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;

  typedef struct {
    logic             op;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] right;
  } pixel_txn_t;

  typedef struct {
    logic signed [DISP_W-1:0] disp;
    logic                     last;
  } disp_txn_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic                     in_op_i;
  logic [PIX_W-1:0]         in_left_pixel_i;
  logic [PIX_W-1:0]         in_right_pixel_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [DISP_W-1:0] out_disparity_o;
  logic                     out_last_pixel_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i;
  logic [DIM_W-1:0]         cfg_data_i;

  ncc_stereo_disparity_unit dut (.*);

  // pending stimulus and expected readback
  pixel_txn_t pixel_pairs[$];
  disp_txn_t  disp_expected[$];

  int  cycles;
  int  errors;
  int  frames_sent;
  int  reads_checked;
  int  phases_run;
  bit  in_taken;
  bit  calm;

  // predictor state
  int  pw, ph, prange, pwin;
  int  raster;
  bit  reading;
  logic [PIX_W-1:0] left_img[MEM_DEPTH];
  logic [PIX_W-1:0] right_img[MEM_DEPTH];
  int  win_shift[MEM_DEPTH];

  // generator view of the current frame size
  int  gw, gh;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // largest q in 0..65536 with q^2 * d1 * d2 <= 2^32 * n^2
  function automatic int ncc_score_q16(longint unsigned n, longint unsigned d1,
                                       longint unsigned d2);
    logic [127:0] lhs, rhs, p;
    longint unsigned lo, hi, mid;
    if (n == 0 || d1 == 0 || d2 == 0) return 0;
    p   = d1 * d2;
    rhs = (128'(n) * 128'(n)) << 32;
    lo  = 0;
    hi  = 65536;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      lhs = 128'(mid) * 128'(mid) * p;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return int'(lo);
  endfunction

  // winning shift for every pixel of the loaded frame
  task automatic score_frame();
    longint unsigned n, d1, d2;
    int best, s, q, x, y, u, v, cx, cy, rv, lv;
    for (y = 0; y < ph; y++) begin
      for (x = 0; x < pw; x++) begin
        best = 0;
        win_shift[y*pw+x] = -1;
        for (s = 0; s <= prange; s++) begin
          n = 0; d1 = 0; d2 = 0;
          for (v = 0; v < pwin; v++) begin
            for (u = 0; u < pwin; u++) begin
              cx = x + u;
              cy = y + v;
              if (cx < pw && cy < ph) begin
                rv = right_img[cy*pw+cx];
                d1 += rv * rv;
                if (cx + s < pw) begin
                  lv = left_img[cy*pw+cx+s];
                  n  += rv * lv;
                  d2 += lv * lv;
                end
              end
            end
          end
          q = ncc_score_q16(n, d1, d2);
          if (q > best) begin
            best = q;
            win_shift[y*pw+x] = s;
          end
        end
        if (win_shift[y*pw+x] == prange) win_shift[y*pw+x] = -1;
      end
    end
  endtask

  function automatic int clamp_dim(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic predict_cfg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
    case (idx)
      REG_IMAGE_WIDTH:  pw     = clamp_dim(int'(data), MAX_WIDTH);
      REG_IMAGE_HEIGHT: ph     = clamp_dim(int'(data), MAX_HEIGHT);
      REG_DISP_RANGE:   prange = clamp_dim(int'(data & 9'h7F), MAX_RANGE);
      REG_WINDOW_SIZE:  pwin   = clamp_dim(int'(data & 9'h1F), MAX_WINDOW);
      default: ;
    endcase
    raster  = 0;
    reading = 1'b0;
  endtask

  task automatic predict_txn(pixel_txn_t t);
    disp_txn_t e;
    int npix;
    npix = pw * ph;
    if (t.op == OP_LOAD) begin
      if (reading) begin
        reading = 1'b0;
        raster  = 0;
      end
      left_img[raster]  = t.left;
      right_img[raster] = t.right;
      raster++;
      if (raster >= npix) begin
        score_frame();
        raster  = 0;
        reading = 1'b1;
      end
    end else if (reading) begin
      e.disp = win_shift[raster][DISP_W-1:0];
      e.last = (raster + 1 == npix);
      disp_expected.push_back(e);
      raster++;
      if (raster >= npix) begin
        raster  = 0;
        reading = 1'b0;
      end
    end
  endtask

  // monitor: check readback, then feed accepted input to the predictor
  always @(posedge clk_i) begin
    disp_txn_t e;
    pixel_txn_t t;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (disp_expected.size() == 0) begin
          errors++;
          $display("%0t: unexpected result disp %0d last %0b", $time,
                   out_disparity_o, out_last_pixel_o);
        end else begin
          e = disp_expected.pop_front();
          reads_checked++;
          if (out_disparity_o !== e.disp) begin
            errors++;
            $display("%0t: disparity expected %0d actual %0d", $time, e.disp,
                     out_disparity_o);
          end
          if (out_last_pixel_o !== e.last) begin
            errors++;
            $display("%0t: last_pixel expected %0b actual %0b", $time, e.last,
                     out_last_pixel_o);
          end
        end
      end
      in_taken = in_valid_i && !in_stall_o;
      if (in_taken) begin
        t.op    = in_op_i;
        t.left  = in_left_pixel_i;
        t.right = in_right_pixel_i;
        predict_txn(t);
      end
    end
  end

  // driver: present the next pixel transaction once the current one is taken
  always @(negedge clk_i) begin
    pixel_txn_t t;
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (pixel_pairs.size() > 0 && (calm || $urandom_range(99) >= 16)) begin
          t = pixel_pairs.pop_front();
          in_op_i          <= t.op;
          in_left_pixel_i  <= t.left;
          in_right_pixel_i <= t.right;
          in_valid_i       <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 16);
    end
  end

  // cycle count, quiet stretch and timeout
  always @(posedge clk_i) begin
    cycles++;
    calm = (cycles >= 30000 && cycles < 80000);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    predict_cfg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // wait until the unit has nothing left in flight, then a margin
  task automatic drain();
    while (pixel_pairs.size() > 0 || in_valid_i || disp_expected.size() > 0 ||
           in_stall_o)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic new_phase(int w, int h, int rng, int win,
                           logic [DIM_W-1:0] wraw, logic [DIM_W-1:0] hraw,
                           logic [DIM_W-1:0] rraw, logic [DIM_W-1:0] nraw);
    drain();
    cfg_write(REG_IMAGE_WIDTH, wraw);
    cfg_write(REG_IMAGE_HEIGHT, hraw);
    cfg_write(REG_DISP_RANGE, rraw);
    cfg_write(REG_WINDOW_SIZE, nraw);
    gw = w;
    gh = h;
    phases_run++;
  endtask

  function automatic pixel_txn_t mk(logic op, logic [PIX_W-1:0] l, logic [PIX_W-1:0] r);
    pixel_txn_t t;
    t.op = op; t.left = l; t.right = r;
    return t;
  endfunction

  // one frame; the right image is mostly the left one shifted so real matches exist
  task automatic push_frame(int reads, bit noise);
    logic [PIX_W-1:0] row[];
    int x, y, d, mode, lv, rv;
    row  = new[gw + 70];
    mode = $urandom_range(9);
    for (y = 0; y < gh; y++) begin
      d = $urandom_range(5);
      foreach (row[i]) row[i] = $urandom;
      for (x = 0; x < gw; x++) begin
        lv = row[x];
        rv = (mode < 7) ? row[x + d] : $urandom;
        if (mode == 7 && $urandom_range(3) == 0) begin
          lv = 0;
        end
        if (mode < 7 && $urandom_range(15) == 0) rv = $urandom;
        if (noise && $urandom_range(19) == 0) pixel_pairs.push_back(mk(OP_READ, $urandom, $urandom));
        pixel_pairs.push_back(mk(OP_LOAD, lv[PIX_W-1:0], rv[PIX_W-1:0]));
      end
    end
    for (x = 0; x < reads; x++) pixel_pairs.push_back(mk(OP_READ, $urandom, $urandom));
    frames_sent++;
  endtask

  int items_queued;
  int k, npx, rd;

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    in_op_i          = OP_LOAD;
    in_left_pixel_i  = '0;
    in_right_pixel_i = '0;
    out_stall_i      = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = REG_IMAGE_WIDTH;
    cfg_data_i       = '0;
    cycles = 0; errors = 0; frames_sent = 0; reads_checked = 0; phases_run = 0;
    in_taken = 1'b0; calm = 1'b0;
    pw = 256; ph = 256; prange = 16; pwin = 5;
    raster = 0; reading = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: 2x2 frames, zero and full-scale pixels, ignored and abandoned reads
    new_phase(2, 2, 1, 1, 9'd2, 9'd2, 9'd1, 9'd1);
    pixel_pairs.push_back(mk(OP_READ, 8'hFF, 8'hFF));
    repeat (4) pixel_pairs.push_back(mk(OP_LOAD, 8'h00, 8'h00));
    repeat (4) pixel_pairs.push_back(mk(OP_READ, 8'h00, 8'h00));
    repeat (4) pixel_pairs.push_back(mk(OP_LOAD, 8'hFF, 8'hFF));
    repeat (2) pixel_pairs.push_back(mk(OP_READ, 8'h00, 8'h00));
    pixel_pairs.push_back(mk(OP_LOAD, 8'h10, 8'h80));
    pixel_pairs.push_back(mk(OP_LOAD, 8'h80, 8'hFF));
    pixel_pairs.push_back(mk(OP_LOAD, 8'h20, 8'h01));
    pixel_pairs.push_back(mk(OP_LOAD, 8'h01, 8'h00));
    repeat (4) pixel_pairs.push_back(mk(OP_READ, 8'h00, 8'h00));
    pixel_pairs.push_back(mk(OP_READ, 8'h00, 8'h00));

    // extreme settings, most written with raw values that need clamping
    new_phase(256, 1, 1, 1, 9'h1FF, 9'd0, 9'd0, 9'd0);
    push_frame(256, 1'b0);
    new_phase(1, 256, 1, 2, 9'd0, 9'd256, 9'h180, 9'h1E2);
    push_frame(256, 1'b0);
    new_phase(1, 1, 64, 16, 9'd1, 9'd1, 9'h1C2, 9'h1F0);
    push_frame(1, 1'b0);
    new_phase(3, 2, 64, 16, 9'd3, 9'd2, 9'd64, 9'd16);
    push_frame(6, 1'b0);

    // random phases of small frames
    items_queued = 0;
    while (items_queued < 640) begin
      k = $urandom_range(1, 5);
      new_phase(0, 0, 0, 0, 9'd0, 9'd0, 9'd0, 9'd0);
      gw = $urandom_range(1, 5);
      gh = $urandom_range(1, 4);
      new_phase(gw, gh, 0, 0, 9'(gw), 9'(gh), 9'($urandom_range(1, 6)),
                9'($urandom_range(1, 5)));
      npx = gw * gh;
      repeat (k) begin
        rd = ($urandom_range(9) == 0) ? $urandom_range(npx) : npx;
        push_frame(rd, 1'b1);
        items_queued += npx + rd;
      end
      push_frame(npx, 1'b0);
      items_queued += 2 * npx;
    end

    drain();
    $display("checked %0d disparities over %0d frames in %0d settings, %0d cycles",
             reads_checked, frames_sent, phases_run, cycles);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/nsd_pkg.sv
hdl/nsd_ctrl.sv
hdl/nsd_datapath.sv
hdl/ncc_stereo_disparity_unit.sv
tb/sv/tb.sv
